[src/bre_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bre_pkg: shared types and constants of the boolean range encoder
// Holds the release word passed from the coder to the byte release sequencer,
// and the fixed constants of the coder.
// ----------------------------------------------------------------------------
package bre_pkg;

    // Width of the 0xff run counter; covers the largest allowed run bound.
    localparam int RUN_W = 6;
    // Width of the per-item byte counter; covers the result limit itself.
    localparam int CNT_W = 7;

    // Coder reset values.
    localparam logic [7:0]  RANGE_RESET = 8'd255;
    localparam logic [5:0]  BC_RESET    = 6'h28;   // minus twenty-four
    localparam logic [31:0] LOW_RESET   = 32'd0;

    // Finish sequence: zero bits coded at one half before the final release.
    localparam logic [5:0] FINISH_STEPS = 6'd32;
    localparam logic [7:0] FINISH_PROB  = 8'd128;

    // Byte values.
    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    // Result limit per item, and the count at which the last allowed byte goes out.
    localparam logic [CNT_W-1:0] CNT_LIMIT = 7'd64;
    localparam logic [CNT_W-1:0] CNT_LAST  = 7'd63;

    // One release of pending bytes: the held byte, then a run of 0xff bytes,
    // all adjusted by the carry.
    typedef struct packed {
        logic             held_valid;
        logic [7:0]       held;
        logic [RUN_W-1:0] run;
        logic             lost;
        logic             carry;
        logic             final_rel;   // last release of its item
        logic             finish;      // release belongs to a finish item
    } t_job;

endpackage
`default_nettype wire

[src/bre_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bre_ifs: channel interfaces of the boolean range encoder
// Input words carry one coding command; output words carry one finished byte.
// ----------------------------------------------------------------------------
interface bre_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic       bit_value;
    logic [7:0] probability;

    modport source (output valid, output func, output bit_value, output probability,
                    input ready);
    modport sink   (input valid, input func, input bit_value, input probability,
                    output ready);
endinterface

interface bre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       stream_end;
    logic       run_overflow;

    modport source (output valid, output out_byte, output last_of_item,
                    output stream_end, output run_overflow, input ready);
    modport sink   (input valid, input out_byte, input last_of_item,
                    input stream_end, input run_overflow, output ready);
endinterface
`default_nettype wire

[src/bre_coder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bre_coder: input register and one-bit coding step
// Codes one bit per cycle from the input register into the range, low and bit
// count (waiting while a release is refused), tracks the held byte and 0xff run,
// and hands pending bytes on when a new byte ends the run or a finish ends.
// ----------------------------------------------------------------------------
module bre_coder #(
    parameter int RUN_MAX = 56
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bre_in_if.sink       i_item,
    output bre_pkg::t_job o_job,
    output logic         o_job_valid,
    input  wire logic    i_job_ready
);
    import bre_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic       r_func;
    logic       r_bit;
    logic [7:0] r_prob;

    // Coder state.
    logic [5:0]       r_fstep;
    logic [7:0]       r_range;
    logic [31:0]      r_low;
    logic [5:0]       r_bc;
    logic [7:0]       r_held;
    logic             r_hv;
    logic [RUN_W-1:0] r_run;
    logic             r_lost;

    logic        cur_bit;
    logic [7:0]  cur_prob;
    logic [15:0] product;
    logic [7:0]  split;
    logic [31:0] low_a;
    logic [7:0]  r_raw;
    logic [3:0]  shift;
    logic [7:0]  range_n;
    logic [6:0]  bc_sum;
    logic [6:0]  bc_adj;
    logic        emit_byte;
    logic [3:0]  offset;
    logic [4:0]  byte_pos;
    logic [31:0] low_tmp;
    logic [31:0] low_sh;
    logic [31:0] low_b;
    logic [31:0] low_c;
    logic [7:0]  new_byte;
    logic        carry;
    logic        is_take;
    logic        nonempty;
    logic        final_step;
    logic        need_job;
    logic        step_go;
    logic        item_done;

    // A finish item codes zero bits at one half.
    assign cur_bit  = r_func ? 1'b0 : r_bit;
    assign cur_prob = r_func ? FINISH_PROB : r_prob;

    // Split point and the new interval.
    assign product = {8'd0, r_range - 8'd1} * {8'd0, cur_prob};
    assign split   = 8'd1 + product[15:8];
    assign low_a   = cur_bit ? r_low + {24'd0, split} : r_low;
    assign r_raw   = cur_bit ? r_range - split : split;

    // Normalizing shift: leading zeros of the new range.
    always_comb begin
        shift = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (r_raw[i]) begin
                shift = 4'(7 - i);
            end
        end
    end

    assign range_n   = r_raw << shift;
    assign bc_sum    = {r_bc[5], r_bc} + {3'b000, shift};
    assign emit_byte = !bc_sum[6];

    // Byte extraction when the bit count crosses zero.
    assign offset   = shift - bc_sum[3:0];
    assign byte_pos = 5'd24 - {1'b0, offset};
    assign low_tmp  = low_a >> byte_pos;
    assign new_byte = low_tmp[7:0];
    assign carry    = low_tmp[8];
    assign low_sh   = low_a << offset;
    assign low_b    = {8'd0, low_sh[23:0]};

    always_comb begin
        if (emit_byte) begin
            low_c  = low_b << bc_sum[2:0];
            bc_adj = bc_sum - 7'd8;
        end else begin
            low_c  = low_a << shift;
            bc_adj = bc_sum;
        end
    end

    // A byte that is not 0xff, or any carry, releases what is pending.
    assign is_take    = emit_byte && ((new_byte != BYTE_ONES) || carry);
    assign nonempty   = r_hv || (r_run != '0);
    assign final_step = r_func && (r_fstep == FINISH_STEPS);
    assign need_job   = final_step || (is_take && nonempty);

    assign o_job_valid = r_in_valid && need_job;
    assign step_go     = r_in_valid && (!need_job || i_job_ready);
    assign item_done   = step_go && (!r_func || final_step);

    assign i_item.ready = !r_in_valid || item_done;

    // Snapshot of the pending bytes.
    always_comb begin
        o_job.held_valid = r_hv;
        o_job.held       = r_held;
        o_job.run        = r_run;
        o_job.lost       = r_lost;
        o_job.carry      = final_step ? 1'b0 : carry;
        o_job.final_rel  = final_step || !r_func;
        o_job.finish     = r_func;
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
        if (i_item.ready && i_item.valid) begin
            r_func <= i_item.func;
            r_bit  <= i_item.bit_value;
            r_prob <= i_item.probability;
        end
    end

    // Coder state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstep <= '0;
            r_range <= RANGE_RESET;
            r_low   <= LOW_RESET;
            r_bc    <= BC_RESET;
            r_held  <= BYTE_ZEROS;
            r_hv    <= 1'b0;
            r_run   <= '0;
            r_lost  <= 1'b0;
        end else if (step_go) begin
            if (final_step) begin
                r_fstep <= '0;
                r_range <= RANGE_RESET;
                r_low   <= LOW_RESET;
                r_bc    <= BC_RESET;
                r_held  <= BYTE_ZEROS;
                r_hv    <= 1'b0;
                r_run   <= '0;
                r_lost  <= 1'b0;
            end else begin
                r_range <= range_n;
                r_low   <= low_c;
                r_bc    <= bc_adj[5:0];
                if (r_func) begin
                    r_fstep <= r_fstep + 6'd1;
                end
                if (is_take) begin
                    r_held <= new_byte;
                    r_hv   <= 1'b1;
                    r_run  <= '0;
                    r_lost <= 1'b0;
                end else if (emit_byte) begin
                    if (r_run < RUN_W'(RUN_MAX)) begin
                        r_run <= r_run + 1'b1;
                    end else begin
                        r_lost <= 1'b1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[src/bre_release.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bre_release: byte release sequencer and output register
// Sends the held byte and then the 0xff run of one release, one byte per cycle
// when the output is free, with carry applied; marks each item's last byte.
// ----------------------------------------------------------------------------
module bre_release (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bre_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    bre_out_if.source          o_word
);
    import bre_pkg::*;

    // Active release.
    logic             r_active;
    logic             r_hv;
    logic [7:0]       r_held;
    logic [RUN_W-1:0] r_run;
    logic             r_carry;
    logic             r_lost;
    logic             r_final;
    logic             r_finish;
    logic [CNT_W-1:0] r_cnt;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_end;
    logic       r_out_ovf;

    logic             slot_free;
    logic             drop;
    logic             emit;
    logic             job_end;
    logic [RUN_W-1:0] rem_after;
    logic             last_item;
    logic [7:0]       cur_byte;
    logic             job_empty;

    assign slot_free = !r_out_valid || o_word.ready;
    assign rem_after = r_hv ? r_run : r_run - 1'b1;
    assign drop      = (r_cnt == CNT_LIMIT);
    assign emit      = r_active && slot_free && !drop;
    assign job_end   = r_active && slot_free && (drop || (rem_after == '0));
    assign last_item = ((rem_after == '0) && r_final) || (r_cnt == CNT_LAST);
    assign cur_byte  = r_hv ? (r_held + {7'd0, r_carry}) : (r_carry ? BYTE_ZEROS : BYTE_ONES);
    assign job_empty = !i_job.held_valid && (i_job.run == '0);

    assign o_job_ready = !r_active || job_end;

    assign o_word.valid        = r_out_valid;
    assign o_word.out_byte     = r_out_byte;
    assign o_word.last_of_item = r_out_last;
    assign o_word.stream_end   = r_out_end;
    assign o_word.run_overflow = r_out_ovf;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= emit;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= last_item;
            r_out_end  <= last_item && r_finish;
            r_out_ovf  <= r_lost;
        end
    end

    // Release sequencing; bytes beyond the per-item limit are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_hv     <= 1'b0;
            r_held   <= BYTE_ZEROS;
            r_run    <= '0;
            r_carry  <= 1'b0;
            r_lost   <= 1'b0;
            r_final  <= 1'b0;
            r_finish <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (r_active && slot_free) begin
                if (drop) begin
                    if (r_final) begin
                        r_cnt <= '0;
                    end
                end else begin
                    if (r_hv) begin
                        r_hv <= 1'b0;
                    end else begin
                        r_run <= r_run - 1'b1;
                    end
                    r_cnt <= ((rem_after == '0) && r_final) ? '0 : r_cnt + 1'b1;
                end
                if (job_end) begin
                    r_active <= 1'b0;
                end
            end
            // Load the next release; an empty final release only ends the item.
            if (i_job_valid && o_job_ready) begin
                if (!job_empty) begin
                    r_active <= 1'b1;
                    r_hv     <= i_job.held_valid;
                    r_held   <= i_job.held;
                    r_run    <= i_job.run;
                    r_carry  <= i_job.carry;
                    r_lost   <= i_job.lost;
                    r_final  <= i_job.final_rel;
                    r_finish <= i_job.finish;
                end else if (i_job.final_rel) begin
                    r_cnt <= '0;
                end
            end
        end
    end

endmodule
`default_nettype wire

[src/boolean_range_encoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// boolean_range_encoder_unit: boolean arithmetic encoder, top level
// Codes bits against 8-bit probabilities and delivers finished bytes with
// carries resolved.
// ----------------------------------------------------------------------------
// An encode word codes one bit, and words can follow each other every cycle.
// A finish word codes 32 zero bits at one half, one per cycle, then releases
// all pending bytes and returns the coder to its reset state for the next
// stream. Output bytes leave one per cycle through a release sequencer: a
// release is a held byte followed by a run of 0xff bytes, and the coder waits
// only when it must start a new release while the previous one is still
// draining, or when the output side stalls. Runs of 0xff longer than RUN_MAX
// are cut short and flagged with run_overflow on every byte of that release.
// The block needs no initialization pass after reset.
// ----------------------------------------------------------------------------
module boolean_range_encoder_unit #(
    parameter int RUN_MAX = 56
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bre_in_if.sink    i_item,
    bre_out_if.source o_word
);
    import bre_pkg::*;

    t_job job;
    logic job_valid;
    logic job_ready;

    // Coding step.
    bre_coder #(
        .RUN_MAX (RUN_MAX)
    ) u_coder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready)
    );

    // Byte release and output register.
    bre_release u_release (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .o_word      (o_word)
    );

endmodule
`default_nettype wire
